/* sv/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  // operand slice handled per multiplier stage
  localparam int CHUNK  = 17;
  // distance result width
  localparam int DIST_W = 32;
  // squared distance width seen by the root unit
  localparam int SQ_W   = 64;

endpackage

`default_nettype wire

/* sv/cpt_dly.sv */
// ----------------------------------------------------------------------------
// cpt_dly
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         ce,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (ce) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

`default_nettype wire

/* sv/cpt_mul.sv */
// ----------------------------------------------------------------------------
// cpt_mul
// Pipelined signed multiplier: one CHUNK-bit slice of b per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_mul import cpt_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic                  clk,
  input  wire logic                  ce,
  input  wire logic signed [AW-1:0]  a,
  input  wire logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0]    p
);

  localparam int NS = (BW + CHUNK - 1) / CHUNK;
  localparam int EW = NS * CHUNK;
  localparam int PW = AW + BW;

  logic signed [AW-1:0] a_r   [NS];
  logic        [EW-1:0] b_r   [NS];
  logic signed [PW-1:0] acc_r [NS];

  // partial product of a with one slice, top slice signed
  function automatic logic signed [PW-1:0] part(input logic signed [AW-1:0] x,
                                                input logic [EW-1:0] y, input int idx);
    logic [CHUNK-1:0]          ch;
    logic signed [AW+CHUNK:0]  pr;
    ch = y[idx*CHUNK +: CHUNK];
    if (idx == NS - 1) begin
      pr = x * $signed(ch);
    end else begin
      pr = x * $signed({1'b0, ch});
    end
    return PW'(pr) <<< (idx * CHUNK);
  endfunction

  // accumulate one slice per stage
  always_ff @(posedge clk) begin
    if (ce) begin
      a_r[0]   <= a;
      b_r[0]   <= EW'(b);
      acc_r[0] <= part(a, EW'(b), 0);
      for (int i = 1; i < NS; i++) begin
        a_r[i]   <= a_r[i-1];
        b_r[i]   <= b_r[i-1];
        acc_r[i] <= acc_r[i-1] + part(a_r[i-1], b_r[i-1], i);
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule

`default_nettype wire

/* sv/cpt_div.sv */
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div #(
  parameter int NW = 8,
  parameter int VW = 8,
  parameter int QB = 4
) (
  input  wire logic          clk,
  input  wire logic          ce,
  input  wire logic [NW-1:0] num,
  input  wire logic [VW-1:0] dvs,
  output logic      [QB-1:0] quo
);

  localparam int TW = NW + VW + QB;

  logic [NW-1:0] rem_r   [QB];
  logic [VW-1:0] dvs_r   [QB];
  logic [QB-1:0] quo_r   [QB];
  logic [NW-1:0] rem_src [QB];
  logic [VW-1:0] dvs_src [QB];
  logic [QB-1:0] quo_src [QB];
  logic [NW-1:0] rem_nxt [QB];
  logic [QB-1:0] quo_nxt [QB];
  logic [TW-1:0] trial   [QB];

  // stage inputs
  always_comb begin
    rem_src[0] = num;
    dvs_src[0] = dvs;
    quo_src[0] = '0;
    for (int k = 1; k < QB; k++) begin
      rem_src[k] = rem_r[k-1];
      dvs_src[k] = dvs_r[k-1];
      quo_src[k] = quo_r[k-1];
    end
  end

  // compare and subtract the shifted divisor
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = TW'(dvs_src[k]) << (QB - 1 - k);
      if (TW'(rem_src[k]) >= trial[k]) begin
        rem_nxt[k] = NW'(TW'(rem_src[k]) - trial[k]);
        quo_nxt[k] = quo_src[k] | (QB'(1) << (QB - 1 - k));
      end else begin
        rem_nxt[k] = rem_src[k];
        quo_nxt[k] = quo_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_src[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

`default_nettype wire

/* sv/cpt_sqrt.sv */
// ----------------------------------------------------------------------------
// cpt_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_sqrt import cpt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              ce,
  input  wire logic [SQ_W-1:0]   x,
  output logic      [DIST_W-1:0] root
);

  localparam int RW = SQ_W + 2;

  logic [RW-1:0]     rem_r    [DIST_W];
  logic [DIST_W-1:0] root_r   [DIST_W];
  logic [RW-1:0]     rem_src  [DIST_W];
  logic [DIST_W-1:0] root_src [DIST_W];
  logic [RW-1:0]     rem_nxt  [DIST_W];
  logic [DIST_W-1:0] root_nxt [DIST_W];
  logic [RW-1:0]     trial    [DIST_W];

  // stage inputs
  always_comb begin
    rem_src[0]  = RW'(x);
    root_src[0] = '0;
    for (int k = 1; k < DIST_W; k++) begin
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
    end
  end

  // remainder holds x - root^2; try the next bit
  always_comb begin
    for (int k = 0; k < DIST_W; k++) begin
      trial[k] = (RW'(root_src[k]) << (DIST_W - k)) + (RW'(1) << (2 * (DIST_W - 1 - k)));
      if (rem_src[k] >= trial[k]) begin
        rem_nxt[k]  = rem_src[k] - trial[k];
        root_nxt[k] = root_src[k] | (DIST_W'(1) << (DIST_W - 1 - k));
      end else begin
        rem_nxt[k]  = rem_src[k];
        root_nxt[k] = root_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < DIST_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[DIST_W-1];

endmodule

`default_nettype wire

/* sv/closest_point_on_triangle_regions.sv */
// Throughput: one item per cycle; the whole pipe advances unless the output item is held.
// Depth is set by the bit-per-stage divider and square root and the sliced multipliers.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// closest_point_on_triangle_regions
// Closest point on a triangle to a query point and the distance to it, using
// exact dot products, seven-region selection, rounded division and a root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_triangle_regions import cpt_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // vertex0_x/y/z, vertex1_x/y/z, vertex2_x/y/z, query_x/y/z from bit 0 up
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // nearest_x, nearest_y, nearest_z, distance from bit 0 up
  output logic [((3*COORD_WIDTH+DIST_W+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic      out_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int DW   = 2 * EW + 2;
  localparam int MW   = 2 * DW;
  localparam int SW   = MW + 2;
  localparam int NAW  = SW + EW;
  localparam int NW1  = NAW + 1;
  localparam int DVW  = NW1 + 2;
  localparam int VSW  = SW + 1;
  localparam int QB   = EW;
  localparam int LA   = (EW + CHUNK - 1) / CHUNK;
  localparam int LB   = (DW + CHUNK - 1) / CHUNK;
  localparam int LC   = (SW + CHUNK - 1) / CHUNK;
  localparam int TS   = LA + LB + 6;
  localparam int TQ   = TS + LC + 2 + QB;
  localparam int TL   = TQ + LA + 3 + DIST_W;
  localparam int XW   = (DW > SQ_W) ? DW : SQ_W + 1;
  localparam int OTW  = ((3*CW + DIST_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    SEL_EDGE_C,
    SEL_EDGE_A,
    SEL_INNER,
    SEL_SPLIT_S,
    SEL_SPLIT_T
  } sel_t;

  logic          ce;
  logic [TL-1:0] vld_r;

  // pipe advances when the output stage is empty or taken
  assign ce         = !out_tvalid || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = vld_r[TL-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[TL-2:0], in_tvalid};
    end
  end

  // clamp a ratio numerator to [0, den]
  function automatic logic signed [SW-1:0] clampr(input logic signed [SW-1:0] num,
                                                  input logic signed [SW-1:0] den);
    if (num <= 0) begin
      return '0;
    end else if (num >= den) begin
      return den;
    end else begin
      return num;
    end
  endfunction

  // ---------------- stage 1: edges and offset ----------------
  logic signed [EW-1:0] e0_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] w_r  [3];
  logic signed [CW-1:0] p0_r [3];
  logic signed [CW-1:0] q_r  [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= $signed(in_tdata[k*CW +: CW]);
        q_r[k]  <= $signed(in_tdata[(9+k)*CW +: CW]);
        e0_r[k] <= EW'($signed(in_tdata[(3+k)*CW +: CW]))
                 - EW'($signed(in_tdata[k*CW +: CW]));
        e1_r[k] <= EW'($signed(in_tdata[(6+k)*CW +: CW]))
                 - EW'($signed(in_tdata[k*CW +: CW]));
        w_r[k]  <= EW'($signed(in_tdata[k*CW +: CW]))
                 - EW'($signed(in_tdata[(9+k)*CW +: CW]));
      end
    end
  end

  // ---------------- dot products ----------------
  logic signed [2*EW-1:0] pa [3];
  logic signed [2*EW-1:0] pb [3];
  logic signed [2*EW-1:0] pc [3];
  logic signed [2*EW-1:0] pd [3];
  logic signed [2*EW-1:0] pe [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    cpt_mul #(.AW(EW), .BW(EW)) u_ma (.clk(clk), .ce(ce), .a(e0_r[k]), .b(e0_r[k]), .p(pa[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mb (.clk(clk), .ce(ce), .a(e0_r[k]), .b(e1_r[k]), .p(pb[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mc (.clk(clk), .ce(ce), .a(e1_r[k]), .b(e1_r[k]), .p(pc[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_md (.clk(clk), .ce(ce), .a(e0_r[k]), .b(w_r[k]),  .p(pd[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_me (.clk(clk), .ce(ce), .a(e1_r[k]), .b(w_r[k]),  .p(pe[k]));
  end

  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;

  // sum of the three coordinate products
  always_ff @(posedge clk) begin
    if (ce) begin
      a_r <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
      b_r <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
      c_r <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
      d_r <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      e_r <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
    end
  end

  // ---------------- determinant and barycentric numerators ----------------
  logic signed [MW-1:0] m_ac, m_bb, m_be, m_cd, m_bd, m_ae;

  cpt_mul #(.AW(DW), .BW(DW)) u_mac (.clk(clk), .ce(ce), .a(a_r), .b(c_r), .p(m_ac));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbb (.clk(clk), .ce(ce), .a(b_r), .b(b_r), .p(m_bb));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbe (.clk(clk), .ce(ce), .a(b_r), .b(e_r), .p(m_be));
  cpt_mul #(.AW(DW), .BW(DW)) u_mcd (.clk(clk), .ce(ce), .a(c_r), .b(d_r), .p(m_cd));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbd (.clk(clk), .ce(ce), .a(b_r), .b(d_r), .p(m_bd));
  cpt_mul #(.AW(DW), .BW(DW)) u_mae (.clk(clk), .ce(ce), .a(a_r), .b(e_r), .p(m_ae));

  logic [5*DW-1:0]      dots_dl;
  logic signed [DW-1:0] a2, b2, c2, d2, e2;

  cpt_dly #(.W(5*DW), .N(LB+1)) u_dots_dly (
    .clk(clk), .ce(ce), .d({e_r, d_r, c_r, b_r, a_r}), .q(dots_dl)
  );

  assign a2 = $signed(dots_dl[0*DW +: DW]);
  assign b2 = $signed(dots_dl[1*DW +: DW]);
  assign c2 = $signed(dots_dl[2*DW +: DW]);
  assign d2 = $signed(dots_dl[3*DW +: DW]);
  assign e2 = $signed(dots_dl[4*DW +: DW]);

  logic signed [SW-1:0] det_r, s_r, t_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      det_r <= SW'(m_ac) - SW'(m_bb);
      s_r   <= SW'(m_be) - SW'(m_cd);
      t_r   <= SW'(m_bd) - SW'(m_ae);
    end
  end

  // ---------------- region stage 1: candidate numerators ----------------
  logic signed [SW-1:0] x1_det_r, x1_s_r, x1_t_r, x1_a_r, x1_c_r;
  logic signed [SW-1:0] x1_ne_r, x1_nd_r, x1_ns_r, x1_nt_r, x1_den_r;
  logic                 x1_stlt_r, x1_dneg_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_det_r  <= det_r;
      x1_s_r    <= s_r;
      x1_t_r    <= t_r;
      x1_a_r    <= SW'(a2);
      x1_c_r    <= SW'(c2);
      x1_ne_r   <= -SW'(e2);
      x1_nd_r   <= -SW'(d2);
      x1_ns_r   <= (SW'(c2) + SW'(e2)) - (SW'(b2) + SW'(d2));
      x1_nt_r   <= (SW'(a2) + SW'(d2)) - (SW'(b2) + SW'(e2));
      x1_den_r  <= SW'(a2) - (SW'(b2) <<< 1) + SW'(c2);
      x1_stlt_r <= (s_r + t_r) < det_r;
      x1_dneg_r <= d2 < 0;
    end
  end

  // ---------------- region stage 2: clamps and region pick ----------------
  sel_t                 sel_nxt;
  logic                 sneg, tneg;
  sel_t                 x2_sel_r;
  logic signed [SW-1:0] x2_det_r, x2_s_r, x2_t_r, x2_a_r, x2_c_r, x2_den_r;
  logic signed [SW-1:0] x2_cle_r, x2_cld_r, x2_cls_r, x2_clt_r;
  logic                 x2_degen_r;

  assign sneg = x1_s_r < 0;
  assign tneg = x1_t_r < 0;

  // seven regions folded onto five ways of forming (den, s, t)
  always_comb begin
    if (x1_stlt_r) begin
      if (sneg && !(tneg && x1_dneg_r)) begin
        sel_nxt = SEL_EDGE_C;
      end else if (sneg || tneg) begin
        sel_nxt = SEL_EDGE_A;
      end else begin
        sel_nxt = SEL_INNER;
      end
    end else if (sneg) begin
      sel_nxt = (x1_ns_r > 0) ? SEL_SPLIT_S : SEL_EDGE_C;
    end else if (tneg) begin
      sel_nxt = (x1_nt_r > 0) ? SEL_SPLIT_T : SEL_EDGE_A;
    end else begin
      sel_nxt = SEL_SPLIT_S;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x2_sel_r   <= sel_nxt;
      x2_det_r   <= x1_det_r;
      x2_s_r     <= x1_s_r;
      x2_t_r     <= x1_t_r;
      x2_a_r     <= x1_a_r;
      x2_c_r     <= x1_c_r;
      x2_den_r   <= x1_den_r;
      x2_cle_r   <= clampr(x1_ne_r, x1_c_r);
      x2_cld_r   <= clampr(x1_nd_r, x1_a_r);
      x2_cls_r   <= clampr(x1_ns_r, x1_den_r);
      x2_clt_r   <= clampr(x1_nt_r, x1_den_r);
      x2_degen_r <= x1_det_r == 0;
    end
  end

  // ---------------- region stage 3: final ratio ----------------
  logic signed [SW-1:0] den_nxt, sn_nxt, tn_nxt;
  logic signed [SW-1:0] den_r, sn_r, tn_r;
  logic                 degen_r;

  always_comb begin
    case (x2_sel_r)
      SEL_EDGE_C: begin
        den_nxt = x2_c_r;
        sn_nxt  = '0;
        tn_nxt  = x2_cle_r;
      end
      SEL_EDGE_A: begin
        den_nxt = x2_a_r;
        sn_nxt  = x2_cld_r;
        tn_nxt  = '0;
      end
      SEL_INNER: begin
        den_nxt = x2_det_r;
        sn_nxt  = x2_s_r;
        tn_nxt  = x2_t_r;
      end
      SEL_SPLIT_S: begin
        den_nxt = x2_den_r;
        sn_nxt  = x2_cls_r;
        tn_nxt  = x2_den_r - x2_cls_r;
      end
      SEL_SPLIT_T: begin
        den_nxt = x2_den_r;
        sn_nxt  = x2_den_r - x2_clt_r;
        tn_nxt  = x2_clt_r;
      end
      default: begin
        den_nxt = x2_det_r;
        sn_nxt  = x2_s_r;
        tn_nxt  = x2_t_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      den_r   <= den_nxt;
      sn_r    <= sn_nxt;
      tn_r    <= tn_nxt;
      degen_r <= x2_degen_r;
    end
  end

  // ---------------- side data delays ----------------
  logic [6*EW-1:0]      edge_dl;
  logic signed [EW-1:0] e0_s [3];
  logic signed [EW-1:0] e1_s [3];
  logic [6*CW-1:0]      pt_dl;

  cpt_dly #(.W(6*EW), .N(TS-1)) u_edge_dly (
    .clk(clk), .ce(ce),
    .d({e1_r[2], e1_r[1], e1_r[0], e0_r[2], e0_r[1], e0_r[0]}),
    .q(edge_dl)
  );

  cpt_dly #(.W(6*CW), .N(TQ-1)) u_pt_dly (
    .clk(clk), .ce(ce),
    .d({q_r[2], q_r[1], q_r[0], p0_r[2], p0_r[1], p0_r[0]}),
    .q(pt_dl)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_s[k] = $signed(edge_dl[k*EW +: EW]);
      e1_s[k] = $signed(edge_dl[(3+k)*EW +: EW]);
    end
  end

  // ---------------- closest point numerators ----------------
  // the wide ratio is sliced so each stage multiplies an edge by one slice
  logic signed [NAW-1:0] pn_s [3];
  logic signed [NAW-1:0] pn_t [3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.AW(EW), .BW(SW)) u_ns (.clk(clk), .ce(ce), .a(e0_s[k]), .b(sn_r), .p(pn_s[k]));
    cpt_mul #(.AW(EW), .BW(SW)) u_nt (.clk(clk), .ce(ce), .a(e1_s[k]), .b(tn_r), .p(pn_t[k]));
  end

  logic signed [SW-1:0]  den_d;
  logic signed [NW1-1:0] n_r [3];
  logic [NW1-1:0]        mag [3];
  logic [DVW-1:0]        dvd_r [3];
  logic [VSW-1:0]        dvs_r;
  logic [2:0]            negp_r;

  cpt_dly #(.W(SW), .N(LC+1)) u_den_dly (.clk(clk), .ce(ce), .d(den_r), .q(den_d));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = n_r[k][NW1-1] ? NW1'(-n_r[k]) : NW1'(n_r[k]);
    end
  end

  // numerator sum, then round-half-away dividend
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k]    <= NW1'(pn_s[k]) + NW1'(pn_t[k]);
        dvd_r[k]  <= (DVW'(mag[k]) << 1) + DVW'($unsigned(den_d));
        negp_r[k] <= n_r[k][NW1-1];
      end
      dvs_r <= VSW'($unsigned(den_d)) << 1;
    end
  end

  logic [QB-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(DVW), .VW(VSW), .QB(QB)) u_div (
      .clk(clk), .ce(ce), .num(dvd_r[k]), .dvs(dvs_r), .quo(quo[k])
    );
  end

  logic [2:0] neg_d;
  logic       degen_d;

  cpt_dly #(.W(3), .N(QB)) u_neg_dly (.clk(clk), .ce(ce), .d(negp_r), .q(neg_d));
  cpt_dly #(.W(1), .N(LC+2+QB)) u_degen_dly (.clk(clk), .ce(ce), .d(degen_r), .q(degen_d));

  // ---------------- closest point ----------------
  logic signed [CW-1:0] p0_d [3];
  logic signed [CW-1:0] nr_r [3];
  logic signed [CW-1:0] qd_r [3];
  logic                 degen1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0_d[k] = $signed(pt_dl[k*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        if (degen_d) begin
          nr_r[k] <= p0_d[k];
        end else if (neg_d[k]) begin
          nr_r[k] <= p0_d[k] - $signed(CW'(quo[k]));
        end else begin
          nr_r[k] <= p0_d[k] + $signed(CW'(quo[k]));
        end
        qd_r[k] <= $signed(pt_dl[(3+k)*CW +: CW]);
      end
      degen1_r <= degen_d;
    end
  end

  // ---------------- distance ----------------
  logic signed [EW-1:0]   df_r [3];
  logic signed [2*EW-1:0] psq  [3];
  logic signed [DW-1:0]   sq_r;
  logic [XW-1:0]          sqx;
  logic                   sat, sat_d;
  logic [DIST_W-1:0]      root;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        df_r[k] <= EW'(nr_r[k]) - EW'(qd_r[k]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    cpt_mul #(.AW(EW), .BW(EW)) u_sq (.clk(clk), .ce(ce), .a(df_r[k]), .b(df_r[k]), .p(psq[k]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_r <= DW'(psq[0]) + DW'(psq[1]) + DW'(psq[2]);
    end
  end

  // root beyond the distance range saturates
  assign sqx = XW'($unsigned(sq_r));
  assign sat = |sqx[XW-1:SQ_W];

  cpt_sqrt u_sqrt (.clk(clk), .ce(ce), .x(sqx[SQ_W-1:0]), .root(root));

  cpt_dly #(.W(1), .N(DIST_W)) u_sat_dly (.clk(clk), .ce(ce), .d(sat), .q(sat_d));

  logic [3*CW:0] res_dl;

  cpt_dly #(.W(3*CW+1), .N(LA+2+DIST_W)) u_res_dly (
    .clk(clk), .ce(ce),
    .d({nr_r[2], nr_r[1], nr_r[0], degen1_r}),
    .q(res_dl)
  );

  // ---------------- output item ----------------
  assign out_tdata = OTW'({(sat_d ? {DIST_W{1'b1}} : root), res_dl[3*CW:1]});
  assign out_tuser = res_dl[0];

endmodule

`default_nettype wire
